/* design/vrc_pkg.sv */
// Shared types, constants and helpers for the Voronoi edge rectangle clipper.
`timescale 1ns / 1ps

package vrc_pkg;

    localparam int W     = 32;            // Q16.16 word
    localparam int FRAC  = 16;            // fraction bits
    localparam int NUM_W = W + 1 + FRAC;  // dividend (c - bound) << 16
    localparam int SUM_W = 2 * W - FRAC + 2;

    localparam logic signed [W-1:0] Q_ONE    = 32'sh0001_0000;
    localparam logic signed [W-1:0] BOX_ZERO = 32'sh0000_0000;
    localparam logic signed [W-1:0] BOX_MAX  = 32'sh0400_0000;

    localparam int FIFO_DEPTH_DEF = 8;

    typedef enum logic [1:0] {
        REG_XMIN = 2'd0,
        REG_YMIN = 2'd1,
        REG_XMAX = 2'd2,
        REG_YMAX = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [W-1:0] xmin;
        logic signed [W-1:0] ymin;
        logic signed [W-1:0] xmax;
        logic signed [W-1:0] ymax;
    } clip_box_t;

    typedef struct packed {
        logic                    need;   // free coordinate must be solved
        logic signed [NUM_W-1:0] num;    // (c - bound) * 65536
        logic signed [W-1:0]     free;   // free coordinate before clipping
        logic signed [W-1:0]     other;  // dependent coordinate, final
    } clip_end_t;

    typedef struct packed {
        logic                vis;
        logic                swap;
        logic                a_one;
        logic signed [W-1:0] k;      // divisor, coefficient of free axis
        clip_end_t           e0;
        clip_end_t           e1;
    } clip_rec_t;

    function automatic logic signed [W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        logic signed [W-1:0]     r;
        hi = {{(SUM_W-W+1){1'b0}}, {(W-1){1'b1}}};
        lo = {{(SUM_W-W+1){1'b1}}, {(W-1){1'b0}}};
        if (v > hi)
        begin
            r = hi[W-1:0];
        end
        else if (v < lo)
        begin
            r = lo[W-1:0];
        end
        else
        begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    // Signed quotient from magnitude and sign, saturated to the word.
    function automatic logic signed [W-1:0] sat_quot(input logic [NUM_W-1:0] mag,
                                                     input logic neg);
        logic [NUM_W-1:0]    lim;
        logic signed [W-1:0] r;
        lim = {{(NUM_W-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
        if (neg)
        begin
            r = (mag > lim) ? $signed(lim[W-1:0]) : -$signed(mag[W-1:0]);
        end
        else
        begin
            r = (mag >= lim) ? $signed(lim[W-1:0] - 1'b1) : $signed(mag[W-1:0]);
        end
        return r;
    endfunction

endpackage

/* design/voronoi_edge_rect_clip.sv */
// Top level: Voronoi edge clipper with clip box registers on an APB port.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid / in_stall       coef_a..right_end_y
//   out      source     out_valid / out_stall     visible, out_left_*, out_right_*
//   cfg      APB slave  psel, penable, pready     paddr[3:2] selects clip bound
//
// One edge per cycle sustained while out_stall stays low; an edge passes 3 front
// stages, queue, 50-stage divider pipe (one bit per stage), output register.
// Reset clears all valids, the queue and the clip box to [0, 1024] on both axes.
// A held output beat freezes the back end; the front keeps filling the queue and
// stalls the input once queue plus in-flight front beats reach FIFO_DEPTH.
`timescale 1ns / 1ps

module voronoi_edge_rect_clip #(
    parameter int FIFO_DEPTH = vrc_pkg::FIFO_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [3:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [vrc_pkg::W-1:0] coef_a,
    input  logic signed [vrc_pkg::W-1:0] coef_b,
    input  logic signed [vrc_pkg::W-1:0] coef_c,
    input  logic                         has_left_end,
    input  logic signed [vrc_pkg::W-1:0] left_end_x,
    input  logic signed [vrc_pkg::W-1:0] left_end_y,
    input  logic                         has_right_end,
    input  logic signed [vrc_pkg::W-1:0] right_end_x,
    input  logic signed [vrc_pkg::W-1:0] right_end_y,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         visible,
    output logic signed [vrc_pkg::W-1:0] out_left_x,
    output logic signed [vrc_pkg::W-1:0] out_left_y,
    output logic signed [vrc_pkg::W-1:0] out_right_x,
    output logic signed [vrc_pkg::W-1:0] out_right_y
);
    import vrc_pkg::*;

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    clip_box_t        box_reg;
    cfg_reg_t         reg_sel;
    logic             cfg_wr;

    logic             push, pop, fifo_empty;
    clip_rec_t        rec_w, rec_r;
    logic [CNT_W-1:0] fifo_count;

    assign pready  = 1'b1;
    assign reg_sel = cfg_reg_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg.xmin <= BOX_ZERO;
            box_reg.ymin <= BOX_ZERO;
            box_reg.xmax <= BOX_MAX;
            box_reg.ymax <= BOX_MAX;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_XMIN: box_reg.xmin <= pwdata;
                REG_YMIN: box_reg.ymin <= pwdata;
                REG_XMAX: box_reg.xmax <= pwdata;
                REG_YMAX: box_reg.ymax <= pwdata;
                default:  box_reg      <= box_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_XMIN: prdata = box_reg.xmin;
            REG_YMIN: prdata = box_reg.ymin;
            REG_XMAX: prdata = box_reg.xmax;
            REG_YMAX: prdata = box_reg.ymax;
            default:  prdata = '0;
        endcase
    end

    vrc_front #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .coef_a        (coef_a),
        .coef_b        (coef_b),
        .coef_c        (coef_c),
        .has_left_end  (has_left_end),
        .left_end_x    (left_end_x),
        .left_end_y    (left_end_y),
        .has_right_end (has_right_end),
        .right_end_x   (right_end_x),
        .right_end_y   (right_end_y),
        .box           (box_reg),
        .fifo_count    (fifo_count),
        .push          (push),
        .rec           (rec_w)
    );

    vrc_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (rec_w),
        .pop     (pop),
        .rd_data (rec_r),
        .empty   (fifo_empty),
        .count   (fifo_count)
    );

    vrc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fifo_empty  (fifo_empty),
        .rec_in      (rec_r),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .visible     (visible),
        .out_left_x  (out_left_x),
        .out_left_y  (out_left_y),
        .out_right_x (out_right_x),
        .out_right_y (out_right_y)
    );

    // queue never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count <= CNT_W'(FIFO_DEPTH))
        else $error("edge queue overfilled");

    // credit scheme: no push into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !pop && fifo_count == CNT_W'(FIFO_DEPTH)))
        else $error("push into full edge queue");

    // a missed edge reports all coordinates as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !visible) |-> (out_left_x == '0 && out_left_y == '0 &&
                                     out_right_x == '0 && out_right_y == '0))
        else $error("invisible edge with nonzero coordinates");

endmodule

/* design/vrc_front.sv */
// Front end: takes edge beats, narrows the free axis, evaluates the line, classifies.
`timescale 1ns / 1ps

module vrc_front #(
    parameter int FIFO_DEPTH = vrc_pkg::FIFO_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [vrc_pkg::W-1:0]        coef_a,
    input  logic signed [vrc_pkg::W-1:0]        coef_b,
    input  logic signed [vrc_pkg::W-1:0]        coef_c,
    input  logic                                has_left_end,
    input  logic signed [vrc_pkg::W-1:0]        left_end_x,
    input  logic signed [vrc_pkg::W-1:0]        left_end_y,
    input  logic                                has_right_end,
    input  logic signed [vrc_pkg::W-1:0]        right_end_x,
    input  logic signed [vrc_pkg::W-1:0]        right_end_y,
    input  vrc_pkg::clip_box_t                  box,
    input  logic [$clog2(FIFO_DEPTH+1)-1:0]     fifo_count,
    output logic                                push,
    output vrc_pkg::clip_rec_t                  rec
);
    import vrc_pkg::*;

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int PND_W = CNT_W + 2;

    // stage 0: captured beat
    logic                s0_valid_reg;
    logic signed [W-1:0] s0_a_reg, s0_b_reg, s0_c_reg;
    logic                s0_hl_reg, s0_hr_reg;
    logic signed [W-1:0] s0_lx_reg, s0_ly_reg, s0_rx_reg, s0_ry_reg;

    // stage 1: free axis ends
    logic                s1_valid_reg;
    logic                s1_a_one_reg, s1_swap_reg, s1_frange_reg;
    logic signed [W-1:0] s1_k_reg, s1_c_reg, s1_f0_reg, s1_f1_reg;
    logic signed [W-1:0] s1_omin_reg, s1_omax_reg;

    // stage 2: products
    logic                  s2_valid_reg;
    logic                  s2_a_one_reg, s2_swap_reg, s2_frange_reg;
    logic signed [W-1:0]   s2_k_reg, s2_c_reg, s2_f0_reg, s2_f1_reg;
    logic signed [W-1:0]   s2_omin_reg, s2_omax_reg;
    logic signed [2*W-1:0] s2_p0_reg, s2_p1_reg;

    logic [PND_W-1:0] pending;
    logic             accept;

    logic                a_one, rev, h0, h1;
    logic signed [W-1:0] v0x, v0y, v1x, v1y;
    logic signed [W-1:0] f0, f1, k, omin, omax;
    logic                frange;

    logic signed [SUM_W-1:0] q0, q1;
    logic signed [W-1:0]     g0, g1, bnd0, bnd1;
    logic                    hi0, hi1, lo0, lo1, vis;
    logic signed [W:0]       dif0, dif1;

    // Credit check: every beat in flight has a slot waiting in the queue.
    assign pending = PND_W'(fifo_count) + PND_W'(s0_valid_reg) + PND_W'(s1_valid_reg)
                   + PND_W'(s2_valid_reg);
    assign in_stall = (pending >= PND_W'(FIFO_DEPTH));
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= accept;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_a_reg  <= coef_a;
            s0_b_reg  <= coef_b;
            s0_c_reg  <= coef_c;
            s0_hl_reg <= has_left_end;
            s0_lx_reg <= left_end_x;
            s0_ly_reg <= left_end_y;
            s0_hr_reg <= has_right_end;
            s0_rx_reg <= right_end_x;
            s0_ry_reg <= right_end_y;
        end
    end

    always_comb
    begin
        a_one = (s0_a_reg == Q_ONE);
        rev   = a_one && !s0_b_reg[W-1];
        h0    = rev ? s0_hr_reg : s0_hl_reg;
        h1    = rev ? s0_hl_reg : s0_hr_reg;
        v0x   = rev ? s0_rx_reg : s0_lx_reg;
        v0y   = rev ? s0_ry_reg : s0_ly_reg;
        v1x   = rev ? s0_lx_reg : s0_rx_reg;
        v1y   = rev ? s0_ly_reg : s0_ry_reg;
        if (a_one)
        begin
            f0   = (h0 && v0y > box.ymin) ? v0y : box.ymin;
            f1   = (h1 && v1y < box.ymax) ? v1y : box.ymax;
            k    = s0_b_reg;
            omin = box.xmin;
            omax = box.xmax;
            frange = (f0 <= box.ymax) && (f1 >= box.ymin);
        end
        else
        begin
            f0   = (h0 && v0x > box.xmin) ? v0x : box.xmin;
            f1   = (h1 && v1x < box.xmax) ? v1x : box.xmax;
            k    = s0_a_reg;
            omin = box.ymin;
            omax = box.ymax;
            frange = (f0 <= box.xmax) && (f1 >= box.xmin);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_a_one_reg  <= a_one;
        s1_swap_reg   <= rev && (s0_hl_reg || s0_hr_reg);
        s1_frange_reg <= frange;
        s1_k_reg      <= k;
        s1_c_reg      <= s0_c_reg;
        s1_f0_reg     <= f0;
        s1_f1_reg     <= f1;
        s1_omin_reg   <= omin;
        s1_omax_reg   <= omax;

        s2_a_one_reg  <= s1_a_one_reg;
        s2_swap_reg   <= s1_swap_reg;
        s2_frange_reg <= s1_frange_reg;
        s2_k_reg      <= s1_k_reg;
        s2_c_reg      <= s1_c_reg;
        s2_f0_reg     <= s1_f0_reg;
        s2_f1_reg     <= s1_f1_reg;
        s2_omin_reg   <= s1_omin_reg;
        s2_omax_reg   <= s1_omax_reg;
        s2_p0_reg     <= s1_k_reg * s1_f0_reg;
        s2_p1_reg     <= s1_k_reg * s1_f1_reg;
    end

    always_comb
    begin
        // arithmetic shift floors the product for both signs
        q0 = SUM_W'($signed(s2_p0_reg[2*W-1:FRAC]));
        q1 = SUM_W'($signed(s2_p1_reg[2*W-1:FRAC]));
        g0 = sat_sum(SUM_W'(s2_c_reg) - q0);
        g1 = sat_sum(SUM_W'(s2_c_reg) - q1);
        hi0 = g0 > s2_omax_reg;
        hi1 = g1 > s2_omax_reg;
        lo0 = g0 < s2_omin_reg;
        lo1 = g1 < s2_omin_reg;
        vis = s2_frange_reg && !((hi0 && hi1) || (lo0 && lo1));
        bnd0 = hi0 ? s2_omax_reg : s2_omin_reg;
        bnd1 = hi1 ? s2_omax_reg : s2_omin_reg;
        dif0 = {s2_c_reg[W-1], s2_c_reg} - {bnd0[W-1], bnd0};
        dif1 = {s2_c_reg[W-1], s2_c_reg} - {bnd1[W-1], bnd1};

        rec.vis      = vis;
        rec.swap     = s2_swap_reg;
        rec.a_one    = s2_a_one_reg;
        rec.k        = s2_k_reg;
        rec.e0.need  = vis && (hi0 || lo0);
        rec.e0.num   = {dif0, {FRAC{1'b0}}};
        rec.e0.free  = s2_f0_reg;
        rec.e0.other = (hi0 || lo0) ? bnd0 : g0;
        rec.e1.need  = vis && (hi1 || lo1);
        rec.e1.num   = {dif1, {FRAC{1'b0}}};
        rec.e1.free  = s2_f1_reg;
        rec.e1.other = (hi1 || lo1) ? bnd1 : g1;
    end

    assign push = s2_valid_reg;

endmodule

/* design/vrc_fifo.sv */
// Short queue of classified edges between front and back end.
`timescale 1ns / 1ps

module vrc_fifo #(
    parameter int FIFO_DEPTH = vrc_pkg::FIFO_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  vrc_pkg::clip_rec_t              wr_data,
    input  logic                            pop,
    output vrc_pkg::clip_rec_t              rd_data,
    output logic                            empty,
    output logic [$clog2(FIFO_DEPTH+1)-1:0] count
);
    import vrc_pkg::*;

    localparam int AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    clip_rec_t        mem_reg [FIFO_DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign empty   = (count_reg == '0);
    assign count   = count_reg;

endmodule

/* design/vrc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, magnitude and sign out.
`timescale 1ns / 1ps

module vrc_div (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [vrc_pkg::NUM_W-1:0] num,
    input  logic signed [vrc_pkg::W-1:0]     den,
    output logic [vrc_pkg::NUM_W-1:0]        quot_mag,
    output logic                             quot_neg
);
    import vrc_pkg::*;

    // nq holds the unconsumed dividend bits in the top, quotient bits shift in below
    logic [NUM_W-1:0] nq_reg  [NUM_W+1];
    logic [W-1:0]     rem_reg [NUM_W+1];
    logic [W-1:0]     dm_reg  [NUM_W+1];
    logic             neg_reg [NUM_W+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nq_reg[0]  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            dm_reg[0]  <= den[W-1] ? W'(-den) : W'(den);
            rem_reg[0] <= '0;
            neg_reg[0] <= num[NUM_W-1] ^ den[W-1];
        end
    end

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_step
        logic [W:0] trial;
        logic       ge;

        assign trial = {rem_reg[i], nq_reg[i][NUM_W-1]};
        assign ge    = trial >= {1'b0, dm_reg[i]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= ge ? W'(trial - {1'b0, dm_reg[i]}) : trial[W-1:0];
                nq_reg[i+1]  <= {nq_reg[i][NUM_W-2:0], ge};
                dm_reg[i+1]  <= dm_reg[i];
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    assign quot_mag = nq_reg[NUM_W];
    assign quot_neg = neg_reg[NUM_W];

endmodule

/* design/vrc_back.sv */
// Back end: solves clipped free coordinates, orders the ends, holds the result beat.
`timescale 1ns / 1ps

module vrc_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fifo_empty,
    input  vrc_pkg::clip_rec_t           rec_in,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         visible,
    output logic signed [vrc_pkg::W-1:0] out_left_x,
    output logic signed [vrc_pkg::W-1:0] out_left_y,
    output logic signed [vrc_pkg::W-1:0] out_right_x,
    output logic signed [vrc_pkg::W-1:0] out_right_y
);
    import vrc_pkg::*;

    localparam int LAT = NUM_W + 1;

    logic      vld_reg [LAT];
    clip_rec_t rec_reg [LAT];
    logic      adv;

    logic [NUM_W-1:0] q0_mag, q1_mag;
    logic             q0_neg, q1_neg;

    logic                out_valid_reg, out_valid_next;
    logic                vis_reg;
    logic signed [W-1:0] lx_reg, ly_reg, rx_reg, ry_reg;

    clip_rec_t           rt;
    logic signed [W-1:0] fr0, fr1, x0, y0, x1, y1;

    // whole back pipe holds while a finished beat waits
    assign adv = !(out_valid_reg && out_stall);
    assign pop = adv && !fifo_empty;

    vrc_div u_div0 (
        .clk      (clk),
        .en       (adv),
        .num      (rec_in.e0.num),
        .den      (rec_in.k),
        .quot_mag (q0_mag),
        .quot_neg (q0_neg)
    );

    vrc_div u_div1 (
        .clk      (clk),
        .en       (adv),
        .num      (rec_in.e1.num),
        .den      (rec_in.k),
        .quot_mag (q1_mag),
        .quot_neg (q1_neg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                vld_reg[0] <= pop;
                for (int i = 1; i < LAT; i++)
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rec_reg[0] <= rec_in;
            for (int i = 1; i < LAT; i++)
            begin
                rec_reg[i] <= rec_reg[i-1];
            end
        end
    end

    always_comb
    begin
        rt  = rec_reg[LAT-1];
        // a zero divisor keeps the unclipped coordinate
        fr0 = (rt.e0.need && rt.k != '0) ? sat_quot(q0_mag, q0_neg) : rt.e0.free;
        fr1 = (rt.e1.need && rt.k != '0) ? sat_quot(q1_mag, q1_neg) : rt.e1.free;
        if (rt.a_one)
        begin
            x0 = rt.e0.other;
            y0 = fr0;
            x1 = rt.e1.other;
            y1 = fr1;
        end
        else
        begin
            x0 = fr0;
            y0 = rt.e0.other;
            x1 = fr1;
            y1 = rt.e1.other;
        end
        out_valid_next = adv ? vld_reg[LAT-1] : out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vis_reg <= rt.vis;
            if (!rt.vis)
            begin
                lx_reg <= '0;
                ly_reg <= '0;
                rx_reg <= '0;
                ry_reg <= '0;
            end
            else if (rt.swap)
            begin
                lx_reg <= x1;
                ly_reg <= y1;
                rx_reg <= x0;
                ry_reg <= y0;
            end
            else
            begin
                lx_reg <= x0;
                ly_reg <= y0;
                rx_reg <= x1;
                ry_reg <= y1;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign visible     = vis_reg;
    assign out_left_x  = lx_reg;
    assign out_left_y  = ly_reg;
    assign out_right_x = rx_reg;
    assign out_right_y = ry_reg;

endmodule
